// ----- src/mte_pkg.sv -----
// Shared types and constants of the median-then-EMA filter.
`default_nettype none

package mte_pkg;

  localparam int WIN_W      = 4;
  localparam int ALPHA_W    = 17;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd1;

  localparam logic [WIN_W-1:0]   WINDOW_RESET = 4'd5;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET  = 17'd6554;
  localparam logic [ALPHA_W-1:0] Q16_ONE      = 17'd65536;
  localparam logic [FRAC_W-1:0]  Q16_HALF     = 16'd32768;

  typedef struct packed {
    logic [WIN_W-1:0] window;
    logic             clear;
  } win_ctl_t;

endpackage

`default_nettype wire

// ----- src/mte_front.sv -----
// Front part: sample history kept as a sorted cell chain and median selection.
`default_nettype none

module mte_front #(
  parameter int MAX_WINDOW,
  parameter int SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mte_pkg::win_ctl_t             win_ctl,
  input  logic                          in_push,
  output logic                          in_full,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          med_push,
  output logic signed [SAMPLE_BITS-1:0] med_data,
  input  logic                          med_full
);

  localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);

  logic signed [SAMPLE_BITS-1:0] val_r [MAX_WINDOW];
  logic [SLOT_W-1:0]             tag_r [MAX_WINDOW];
  logic [CNT_W-1:0]              fill_r, fill_nxt;
  logic [SLOT_W-1:0]             slot_r, slot_nxt;
  logic                          pend_r;

  logic                          accept;
  logic [SLOT_W-1:0]             wslot;
  logic                          del;
  logic [CNT_W-1:0]              live;
  logic [MAX_WINDOW-1:0]         dmatch, pre, gt;
  logic signed [SAMPLE_BITS-1:0] cm_v [MAX_WINDOW];
  logic [SLOT_W-1:0]             cm_t [MAX_WINDOW];
  logic signed [SAMPLE_BITS-1:0] new_v [MAX_WINDOW];
  logic [SLOT_W-1:0]             new_t [MAX_WINDOW];
  logic [CNT_W-1:0]              half;
  logic [SLOT_W-1:0]             mid_idx;

  assign accept  = in_push && !in_full;
  assign in_full = pend_r;

  always_comb begin
    wslot = slot_r;
    if ((int'(slot_r) >= int'(win_ctl.window)) || (int'(slot_r) >= MAX_WINDOW)) begin
      wslot = '0;
    end
    del  = (int'(fill_r) >= int'(win_ctl.window)) || (int'(fill_r) >= MAX_WINDOW);
    live = CNT_W'(fill_r - CNT_W'(del));
    fill_nxt = del ? fill_r : CNT_W'(fill_r + 1'b1);
    if ((int'(wslot) + 1 >= int'(win_ctl.window)) || (int'(wslot) + 1 >= MAX_WINDOW)) begin
      slot_nxt = '0;
    end else begin
      slot_nxt = SLOT_W'(wslot + 1'b1);
    end
  end

  // Each cell drops the sample that leaves the window and makes room for the new one.
  for (genvar k = 0; k < MAX_WINDOW; k++) begin : g_cell
    assign dmatch[k] = del && (k < int'(fill_r)) && (tag_r[k] == wslot);

    if (k == 0) begin : g_pre_first
      assign pre[k] = dmatch[k];
    end else begin : g_pre_rest
      assign pre[k] = pre[k-1] | dmatch[k];
    end

    if (k < MAX_WINDOW - 1) begin : g_shift
      assign cm_v[k] = pre[k] ? val_r[k+1] : val_r[k];
      assign cm_t[k] = pre[k] ? tag_r[k+1] : tag_r[k];
    end else begin : g_last
      assign cm_v[k] = val_r[k];
      assign cm_t[k] = tag_r[k];
    end

    assign gt[k] = !(k < int'(live)) || (cm_v[k] > in_sample);

    if (k == 0) begin : g_ins_first
      assign new_v[k] = gt[k] ? in_sample : cm_v[k];
      assign new_t[k] = gt[k] ? wslot : cm_t[k];
    end else begin : g_ins_rest
      assign new_v[k] = !gt[k] ? cm_v[k] : (!gt[k-1] ? in_sample : cm_v[k-1]);
      assign new_t[k] = !gt[k] ? cm_t[k] : (!gt[k-1] ? wslot : cm_t[k-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      slot_r <= '0;
      pend_r <= 1'b0;
    end else begin
      if (win_ctl.clear) begin
        fill_r <= '0;
        slot_r <= '0;
      end else if (accept) begin
        fill_r <= fill_nxt;
        slot_r <= slot_nxt;
      end
      if (accept) begin
        pend_r <= 1'b1;
      end else if (pend_r && !med_full) begin
        pend_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < MAX_WINDOW; k++) begin
        val_r[k] <= new_v[k];
        tag_r[k] <= new_t[k];
      end
    end
  end

  assign half     = fill_r >> 1;
  assign mid_idx  = half[SLOT_W-1:0];
  assign med_push = pend_r && !med_full;
  assign med_data = val_r[mid_idx];

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(fill_r) <= MAX_WINDOW)
    else $error("Fill count exceeds the window depth.");

  a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !win_ctl.clear) |=> (fill_r != '0))
    else $error("Fill count is zero after a sample transfer.");

  a_pend_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && !med_full) |=> !pend_r)
    else $error("Median stays pending after its transfer.");

endmodule

`default_nettype wire

// ----- src/mte_queue.sv -----
// Two-entry queue of medians between the front and the back part.
`default_nettype none

module mte_queue #(
  parameter int WIDTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  logic [WIDTH-1:0] q_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       cnt_r;
  logic             do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ----- src/mte_back.sv -----
// Back part: Q16 exponential low-pass filter and the result register.
`default_nettype none

module mte_back #(
  parameter int SAMPLE_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [mte_pkg::ALPHA_W-1:0]     alpha,
  input  logic                            q_empty,
  input  logic signed [SAMPLE_BITS-1:0]   q_data,
  output logic                            q_pop,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic signed [SAMPLE_BITS-1:0]   out_median_value,
  output logic signed [SAMPLE_BITS-1:0]   out_filtered_value
);

  localparam int FW    = mte_pkg::FRAC_W;
  localparam int AW    = mte_pkg::ALPHA_W;
  localparam int ACC_W = SAMPLE_BITS + FW;
  localparam int DIF_W = ACC_W + 1;
  localparam int HI_W  = SAMPLE_BITS + 1;
  localparam int PH_W  = HI_W + AW + 1;
  localparam int INC_W = PH_W + 1;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_ACC  = 2'b10
  } back_state_t;

  back_state_t                   state_r, state_nxt;
  logic signed [ACC_W-1:0]       acc_r, acc_nxt;
  logic                          seeded_r;
  logic signed [SAMPLE_BITS-1:0] med_r;
  logic signed [PH_W-1:0]        phi_r, phi_nxt;
  logic [AW-1:0]                 plo_r, plo_nxt;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_med_r, out_filt_r;

  logic signed [DIF_W-1:0]       diff;
  logic signed [HI_W-1:0]        hi;
  logic [FW-1:0]                 lo;
  logic [AW+FW-1:0]              plo_prod, plo_sum;
  logic signed [INC_W-1:0]       inc, acc_sum;
  logic signed [ACC_W:0]         rnd;
  logic                          load_out;

  assign diff     = {q_data[SAMPLE_BITS-1], q_data, {FW{1'b0}}} - {acc_r[ACC_W-1], acc_r};
  assign hi       = diff[DIF_W-1:FW];
  assign lo       = diff[FW-1:0];
  assign phi_nxt  = $signed({1'b0, alpha}) * hi;
  assign plo_prod = alpha * lo;
  assign plo_sum  = plo_prod + (AW+FW)'(mte_pkg::Q16_HALF);
  assign plo_nxt  = plo_sum[AW+FW-1:FW];

  assign inc     = INC_W'(phi_r) + $signed(INC_W'({1'b0, plo_r}));
  assign acc_sum = INC_W'(acc_r) + inc;
  assign acc_nxt = seeded_r ? acc_sum[ACC_W-1:0] : {med_r, {FW{1'b0}}};
  assign rnd     = {acc_nxt[ACC_W-1], acc_nxt} + (ACC_W+1)'(mte_pkg::Q16_HALF);

  assign load_out = (state_r == B_ACC) && (!out_valid_r || out_pop);

  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          state_nxt = B_ACC;
        end
      end
      B_ACC: begin
        if (load_out) begin
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      acc_r       <= '0;
      seeded_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        acc_r       <= acc_nxt;
        seeded_r    <= 1'b1;
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      med_r <= q_data;
      phi_r <= phi_nxt;
      plo_r <= plo_nxt;
    end
    if (load_out) begin
      out_med_r  <= med_r;
      out_filt_r <= rnd[ACC_W-1:FW];
    end
  end

  assign out_empty          = !out_valid_r;
  assign out_median_value   = out_med_r;
  assign out_filtered_value = out_filt_r;

endmodule

`default_nettype wire

// ----- src/median_then_ema_filter_top.sv -----
// Top level of the median-then-EMA filter: configuration registers and the part wiring.
`default_nettype none

// The block takes one signed sample per transfer on the input queue port (in_push, in_full)
// and returns one result per sample on the output queue port (out_empty, out_pop): the
// median of the last window_size samples (of all samples so far while the window fills)
// and that median passed through a Q16 exponential low-pass filter, rounded to an integer.
// The first median after reset loads the filter directly.
// Configuration goes through cfg_valid/cfg_ready with cfg_index and cfg_wdata; cfg_ready is
// always high. Index 0 sets the window size (odd, nonzero, not above MAX_WINDOW, otherwise
// ignored) and restarts the history; index 1 sets alpha (1 to 65536, otherwise ignored).
// Write configuration only while no result is outstanding.
// The front registers each sample into the sorted history cells and then selects the median
// from them, and takes no new sample until that median has gone into the queue; the back
// registers the alpha multiply and then updates the accumulator and the result register.
// Reset clears the history, the filter state, the median queue and the result register, and
// restores window size 5 and alpha 6554. When the receiver stalls, the result register and a
// two-entry median queue fill up, after which in_full stays high until results are taken.
module median_then_ema_filter_top #(
  parameter int MAX_WINDOW  = 15,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic signed [SAMPLE_BITS-1:0]       in_sample,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic signed [SAMPLE_BITS-1:0]       out_median_value,
  output logic signed [SAMPLE_BITS-1:0]       out_filtered_value,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mte_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mte_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  logic [mte_pkg::WIN_W-1:0]   window_r;
  logic [mte_pkg::ALPHA_W-1:0] alpha_r;
  logic [mte_pkg::WIN_W-1:0]   wr_window;
  logic [mte_pkg::ALPHA_W-1:0] wr_alpha;
  logic                        cfg_wr, win_wr, alpha_wr;
  mte_pkg::win_ctl_t           win_ctl;

  logic                          med_push, med_full, q_pop, q_empty;
  logic signed [SAMPLE_BITS-1:0] med_data, q_data;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign wr_window = cfg_wdata[mte_pkg::WIN_W-1:0];
  assign wr_alpha  = cfg_wdata[mte_pkg::ALPHA_W-1:0];

  always_comb begin
    win_wr   = 1'b0;
    alpha_wr = 1'b0;
    unique case (cfg_index)
      mte_pkg::REG_WINDOW: begin
        win_wr = cfg_wr && (wr_window != '0) && wr_window[0]
                 && (int'(wr_window) <= MAX_WINDOW);
      end
      mte_pkg::REG_ALPHA: begin
        alpha_wr = cfg_wr && (wr_alpha != '0) && (wr_alpha <= mte_pkg::Q16_ONE);
      end
      default: begin
        win_wr   = 1'b0;
        alpha_wr = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= mte_pkg::WINDOW_RESET;
      alpha_r  <= mte_pkg::ALPHA_RESET;
    end else begin
      if (win_wr) begin
        window_r <= wr_window;
      end
      if (alpha_wr) begin
        alpha_r <= wr_alpha;
      end
    end
  end

  assign win_ctl.window = window_r;
  assign win_ctl.clear  = win_wr;

  mte_front #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .win_ctl   (win_ctl),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_sample (in_sample),
    .med_push  (med_push),
    .med_data  (med_data),
    .med_full  (med_full)
  );

  mte_queue #(
    .WIDTH (SAMPLE_BITS)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (med_push),
    .push_data (med_data),
    .full      (med_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  mte_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .alpha              (alpha_r),
    .q_empty            (q_empty),
    .q_data             (q_data),
    .q_pop              (q_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_median_value   (out_median_value),
    .out_filtered_value (out_filtered_value)
  );

endmodule

`default_nettype wire
